FILE: hw/rtl/wsc_pkg.sv
`timescale 1ns / 1ps

package wsc_pkg;

  localparam int TABLE_DEPTH     = 32;
  localparam int SPEED_FRAC_BITS = 8;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int KIND_W   = 3;
  localparam int DUTY_W   = 12;
  localparam int SPEED_W  = 24;
  localparam int FACT_W   = 20;
  localparam int LIMIT_W  = 10;
  localparam int STATUS_W = 3;
  localparam int GAIN_W   = 6;
  localparam int OFFS_W   = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Datapath widths of the duty update.
  localparam int LIMQ_W = LIMIT_W + SPEED_FRAC_BITS;
  localparam int CMP_W  = ((FACT_W > LIMQ_W + 1) ? FACT_W : LIMQ_W + 1) + 1;
  localparam int OPA_W  = ((SPEED_W + 1 > FACT_W) ? SPEED_W + 1 : FACT_W);
  localparam int PROD_W = OPA_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + SPEED_FRAC_BITS + 2;

  localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACKWARD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REGULATE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_STEER    = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_CAL    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_BRACKET = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 12'd1000;
  localparam logic [GAIN_W-1:0] GAIN_RESET     = 6'd5;
  localparam logic [OFFS_W-1:0] OFFSET_RESET   = 10'd10;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [DUTY_W-1:0]         entry_duty;
    logic [SPEED_W-1:0]        speed_value;
    logic [SPEED_W-1:0]        measured_speed;
    logic signed [FACT_W-1:0]  steer_factor;
    logic [LIMIT_W-1:0]        steer_limit;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic                drive_forward;
    logic                drive_backward;
    logic [STATUS_W-1:0] status;
    logic [SPEED_W-1:0]  lowest_speed;
    logic [SPEED_W-1:0]  highest_speed;
    logic                moving;
  } result_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [SPEED_W-1:0] speed;
  } entry_t;

  // Operands handed to the duty update unit.
  typedef struct packed {
    logic                     steer;
    logic                     fwd;
    logic [DUTY_W-1:0]        duty_reg;
    logic [DUTY_W-1:0]        base_duty;
    logic [SPEED_W-1:0]       speed;
    logic [SPEED_W-1:0]       measured;
    logic signed [FACT_W-1:0] factor;
    logic [LIMIT_W-1:0]       limit;
  } calc_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_max;
    logic [GAIN_W-1:0] gain;
    logic [OFFS_W-1:0] steer_offset;
  } cfg_t;

endpackage

FILE: hw/rtl/wsc_table.sv
`timescale 1ns / 1ps

module wsc_table
  import wsc_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/wsc_calc.sv
`timescale 1ns / 1ps

module wsc_calc
  import wsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  calc_req_t         req,
  input  cfg_t              cfg,
  output logic              valid,
  output logic [DUTY_W-1:0] duty
);

  logic signed [CMP_W-1:0] factor_ext;
  logic signed [CMP_W-1:0] lim_ext;
  logic                    above;
  logic                    below;

  logic signed [OPA_W-1:0] opa_s1;
  logic                    big_s1;
  logic                    neg_s1;
  logic [DUTY_W-1:0]       base_s1;
  logic                    v1;

  logic signed [PROD_W-1:0] prod_s2;
  logic                     big_s2;
  logic                     neg_s2;
  logic [DUTY_W-1:0]        base_s2;
  logic                     v2;

  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] total;
  logic [SUM_W-1:0]        whole;
  logic [DUTY_W-1:0]       duty_sat;

  assign factor_ext = CMP_W'(req.factor);
  assign lim_ext    = $signed(CMP_W'({req.limit, {SPEED_FRAC_BITS{1'b0}}}));
  assign above      = factor_ext > lim_ext;
  assign below      = factor_ext < -lim_ext;

  // Stage 1: pick the multiplier operand and the sign of the correction.
  always_ff @(posedge clk) begin
    if (go) begin
      if (!req.steer) begin
        opa_s1 <= $signed(OPA_W'({1'b0, req.speed})) - $signed(OPA_W'({1'b0, req.measured}));
      end else if (above || below) begin
        opa_s1 <= $signed(OPA_W'(req.limit));
      end else begin
        opa_s1 <= OPA_W'(req.factor);
      end
      big_s1  <= req.steer && (above || below);
      // Steering pushes up when going forward; beyond the lower limit it flips.
      neg_s1  <= req.steer && (req.fwd == below);
      base_s1 <= req.steer ? req.base_duty : req.duty_reg;
    end
  end

  // Stage 2: the single multiplication by the gain.
  always_ff @(posedge clk) begin
    prod_s2 <= opa_s1 * $signed({1'b0, cfg.gain});
    big_s2  <= big_s1;
    neg_s2  <= neg_s1;
    base_s2 <= base_s1;
  end

  always_comb begin
    if (big_s2) begin
      term = (SUM_W'(prod_s2) + $signed(SUM_W'({1'b0, cfg.steer_offset})))
             <<< SPEED_FRAC_BITS;
    end else begin
      term = SUM_W'(prod_s2);
    end
    total = $signed(SUM_W'({base_s2, {SPEED_FRAC_BITS{1'b0}}})) + (neg_s2 ? -term : term);
    whole = SUM_W'(total >>> SPEED_FRAC_BITS);
    if (total <= 0) begin
      duty_sat = '0;
    end else if (whole > SUM_W'(cfg.duty_max)) begin
      duty_sat = cfg.duty_max;
    end else begin
      duty_sat = whole[DUTY_W-1:0];
    end
  end

  // Stage 3: saturated duty.
  always_ff @(posedge clk) begin
    duty <= duty_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= go;
      v2    <= v1;
      valid <= v2;
    end
  end

endmodule

FILE: hw/rtl/wheel_speed_controller.sv
`timescale 1ns / 1ps
// Channel   Ports                                        Beat taken when
// command   start, busy, cmd                             start && !busy
// result    done, result                                 done (one cycle, no back-pressure)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// Direction, stop, clear and load commands answer in the cycle after the command beat.
// Regulate and steer pass through the three-stage duty update unit.
// Set speed scans the calibration table memory one entry per cycle, a rate that the
// single read port sets.
// Reset is synchronous and leaves the table contents undefined; no clearing pass.
// Busy stays high while a command is at work; results are never stalled.

module wheel_speed_controller
  import wsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  logic [1:0] state;

  cfg_t cfg;

  logic                fwd_flag;
  logic                bwd_flag;
  logic [DUTY_W-1:0]   duty_reg;
  logic [DUTY_W-1:0]   base_duty;
  logic                is_calibrated;
  logic [CNT_W-1:0]    entry_count;
  logic [SPEED_W-1:0]  min_seen;
  logic [SPEED_W-1:0]  max_seen;
  logic [STATUS_W-1:0] status;

  logic accept;
  logic moving;
  logic table_full;

  // Scan bookkeeping.
  logic [CNT_W-1:0]   issue_cnt;
  logic               rd_en;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             rd_data;
  entry_t             prev;
  logic [SPEED_W-1:0] target;
  logic               hit;
  logic               last;

  logic              tbl_we;
  entry_t            tbl_wdata;

  calc_req_t         calc_req;
  logic              calc_go;
  logic              calc_valid;
  logic [DUTY_W-1:0] calc_duty;

  assign busy       = state != ST_IDLE;
  assign accept     = start && !busy;
  assign moving     = fwd_flag || bwd_flag;
  assign table_full = entry_count >= CNT_W'(TABLE_DEPTH);
  assign cfg_ready  = 1'b1;

  assign tbl_we          = accept && (cmd.kind == KIND_LOAD) && !table_full;
  assign tbl_wdata.duty  = cmd.entry_duty;
  assign tbl_wdata.speed = cmd.speed_value;

  assign rd_en = (state == ST_SCAN) && (issue_cnt < entry_count);
  assign hit   = (rd_idx != '0) && (prev.speed <= target) && (rd_data.speed >= target);
  assign last  = CNT_W'(rd_idx) == (entry_count - CNT_W'(1));

  assign calc_go = accept && moving &&
                   ((cmd.kind == KIND_REGULATE) || (cmd.kind == KIND_STEER));

  assign calc_req.steer     = cmd.kind == KIND_STEER;
  assign calc_req.fwd       = fwd_flag;
  assign calc_req.duty_reg  = duty_reg;
  assign calc_req.base_duty = base_duty;
  assign calc_req.speed     = cmd.speed_value;
  assign calc_req.measured  = cmd.measured_speed;
  assign calc_req.factor    = cmd.steer_factor;
  assign calc_req.limit     = cmd.steer_limit;

  wsc_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (tbl_wdata),
    .re    (rd_en),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  wsc_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .go    (calc_go),
    .req   (calc_req),
    .cfg   (cfg),
    .valid (calc_valid),
    .duty  (calc_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_max     <= DUTY_MAX_RESET;
      cfg.gain         <= GAIN_RESET;
      cfg.steer_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DUTY_MAX: cfg.duty_max     <= cfg_data[DUTY_W-1:0];
        CFG_GAIN:     cfg.gain         <= cfg_data[GAIN_W-1:0];
        CFG_OFFSET:   cfg.steer_offset <= cfg_data[OFFS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Payload side of the scan: target speed, previous entry, read tag.
  always_ff @(posedge clk) begin
    if (accept) begin
      target <= cmd.speed_value;
    end
    if (rd_vld) begin
      prev <= rd_data;
    end
    rd_idx <= issue_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      fwd_flag      <= 1'b0;
      bwd_flag      <= 1'b0;
      duty_reg      <= '0;
      base_duty     <= '0;
      is_calibrated <= 1'b0;
      entry_count   <= '0;
      min_seen      <= '1;
      max_seen      <= '0;
      status        <= STATUS_OK;
      issue_cnt     <= '0;
      rd_vld        <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= rd_en;
      if (rd_en) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            status <= STATUS_OK;
            done   <= 1'b1;
            unique case (cmd.kind) inside
              KIND_FORWARD: begin
                fwd_flag <= 1'b1;
                bwd_flag <= 1'b0;
              end
              KIND_BACKWARD: begin
                bwd_flag <= 1'b1;
              end
              KIND_STOP: begin
                fwd_flag <= 1'b0;
                bwd_flag <= 1'b0;
              end
              KIND_CLEAR: begin
                entry_count   <= '0;
                min_seen      <= '1;
                max_seen      <= '0;
                is_calibrated <= 1'b0;
              end
              KIND_LOAD: begin
                if (table_full) begin
                  status <= STATUS_FULL;
                end else begin
                  entry_count   <= entry_count + CNT_W'(1);
                  is_calibrated <= 1'b1;
                  if (cmd.speed_value > max_seen) begin
                    max_seen <= cmd.speed_value;
                  end
                  if (cmd.speed_value < min_seen) begin
                    min_seen <= cmd.speed_value;
                  end
                end
              end
              KIND_SET: begin
                if (!is_calibrated) begin
                  status <= STATUS_NOT_CAL;
                end else if (cmd.speed_value < min_seen || cmd.speed_value > max_seen) begin
                  status <= STATUS_RANGE;
                end else if (entry_count < CNT_W'(2)) begin
                  status <= STATUS_NO_BRACKET;
                end else begin
                  done      <= 1'b0;
                  issue_cnt <= '0;
                  state     <= ST_SCAN;
                end
              end
              KIND_REGULATE, KIND_STEER: begin
                if (moving) begin
                  done  <= 1'b0;
                  state <= ST_CALC;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // The first neighboring pair that brackets the target wins.
          if (rd_vld) begin
            if (hit) begin
              base_duty <= prev.duty;
              duty_reg  <= (prev.duty > cfg.duty_max) ? cfg.duty_max : prev.duty;
              status    <= STATUS_OK;
              done      <= 1'b1;
              state     <= ST_IDLE;
            end else if (last) begin
              status <= STATUS_NO_BRACKET;
              done   <= 1'b1;
              state  <= ST_IDLE;
            end
          end
        end
        ST_CALC: begin
          if (calc_valid) begin
            duty_reg <= calc_duty;
            status   <= STATUS_OK;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.duty           = duty_reg;
  assign result.drive_forward  = fwd_flag && !bwd_flag;
  assign result.drive_backward = bwd_flag;
  assign result.status         = status;
  assign result.lowest_speed   = min_seen;
  assign result.highest_speed  = max_seen;
  assign result.moving         = moving;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("calibration entry count beyond table depth");

  a_calibrated: assert property (@(posedge clk) disable iff (rst)
    is_calibrated == (entry_count != '0))
    else $error("calibration flag disagrees with entry count");

  a_calc_in_state: assert property (@(posedge clk) disable iff (rst)
    calc_valid |-> state == ST_CALC)
    else $error("duty update finished outside its wait state");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result beat without a command at work");

endmodule

FILE: tb/tb_wheel_speed_controller.sv
`timescale 1ns / 1ps

module tb_wheel_speed_controller;
  import wsc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1850;
  localparam longint SPEED_TOP = (longint'(1) << SPEED_W) - 1;
  // Index 3 is not a register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  cmd_t                  cmd = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wheel_speed_controller dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Controller state as the testbench predicts it.
  logic [DUTY_W-1:0]  duty_max_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [OFFS_W-1:0]  offset_r;
  logic               fwd_now;
  logic               bwd_now;
  logic [DUTY_W-1:0]  duty_now;
  logic [DUTY_W-1:0]  base_now;
  logic               calibrated;
  logic [DUTY_W-1:0]  cal_duty [TABLE_DEPTH];
  logic [SPEED_W-1:0] cal_speed [TABLE_DEPTH];
  int                 cal_count;
  logic [SPEED_W-1:0] speed_lo;
  logic [SPEED_W-1:0] speed_hi;

  result_t pending_results[$];
  int      cmds_sent = 0;
  int      results_seen = 0;
  int      regs_written = 0;
  int      bracket_hits = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      gap_odds = 0;
  bit      quiet_tail = 1'b0;

  function automatic logic [DUTY_W-1:0] clip_duty(input longint scaled);
    longint whole;
    if (scaled <= 0) return '0;
    whole = scaled >>> SPEED_FRAC_BITS;
    if (whole > longint'(duty_max_r)) return duty_max_r;
    return whole[DUTY_W-1:0];
  endfunction

  // Updates the predicted state for one command and returns the expected result after it.
  function automatic result_t apply_command(input cmd_t c);
    result_t             r;
    logic [STATUS_W-1:0] st;
    logic                was_moving;
    bit                  found;
    int                  i;
    longint              factor, lim, big, delta, dir, total;
    st = STATUS_OK;
    was_moving = fwd_now | bwd_now;
    factor = longint'($signed(c.steer_factor));
    case (c.kind)
      KIND_FORWARD: begin
        fwd_now = 1'b1;
        bwd_now = 1'b0;
      end
      KIND_BACKWARD: bwd_now = 1'b1;
      KIND_STOP: begin
        fwd_now = 1'b0;
        bwd_now = 1'b0;
      end
      KIND_CLEAR: begin
        cal_count = 0;
        speed_lo = '1;
        speed_hi = '0;
        calibrated = 1'b0;
      end
      KIND_LOAD: begin
        if (cal_count >= TABLE_DEPTH) begin
          st = STATUS_FULL;
        end else begin
          cal_duty[cal_count] = c.entry_duty;
          cal_speed[cal_count] = c.speed_value;
          cal_count++;
          if (c.speed_value > speed_hi) speed_hi = c.speed_value;
          if (c.speed_value < speed_lo) speed_lo = c.speed_value;
          calibrated = 1'b1;
        end
      end
      KIND_SET: begin
        if (!calibrated) begin
          st = STATUS_NOT_CAL;
        end else if (c.speed_value < speed_lo || c.speed_value > speed_hi) begin
          st = STATUS_RANGE;
        end else begin
          st = STATUS_NO_BRACKET;
          found = 1'b0;
          for (i = 0; i + 1 < cal_count && !found; i++) begin
            if (cal_speed[i] <= c.speed_value && cal_speed[i + 1] >= c.speed_value) begin
              base_now = cal_duty[i];
              duty_now = (base_now > duty_max_r) ? duty_max_r : base_now;
              st = STATUS_OK;
              found = 1'b1;
              bracket_hits++;
            end
          end
        end
      end
      KIND_REGULATE: begin
        if (was_moving) begin
          total = (longint'(duty_now) << SPEED_FRAC_BITS)
                + (longint'(c.speed_value) - longint'(c.measured_speed)) * longint'(gain_r);
          duty_now = clip_duty(total);
        end
      end
      default: begin
        if (was_moving) begin
          dir = fwd_now ? 1 : -1;
          lim = longint'(c.steer_limit) << SPEED_FRAC_BITS;
          big = (longint'(offset_r) + longint'(c.steer_limit) * longint'(gain_r))
                << SPEED_FRAC_BITS;
          if (factor > lim) delta = dir * big;
          else if (factor < -lim) delta = -dir * big;
          else delta = dir * factor * longint'(gain_r);
          duty_now = clip_duty((longint'(base_now) << SPEED_FRAC_BITS) + delta);
        end
      end
    endcase
    r.duty = duty_now;
    r.drive_forward = fwd_now & ~bwd_now;
    r.drive_backward = bwd_now;
    r.status = st;
    r.lowest_speed = speed_lo;
    r.highest_speed = speed_hi;
    r.moving = fwd_now | bwd_now;
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SPEED_W'($urandom_range(0, 65535));
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  function automatic cmd_t rand_cmd(input logic [KIND_W-1:0] k);
    cmd_t c;
    c.kind = k;
    c.entry_duty = DUTY_W'($urandom);
    c.speed_value = rand_speed();
    c.measured_speed = rand_speed();
    c.steer_factor = FACT_W'($urandom);
    c.steer_limit = LIMIT_W'($urandom_range(0, 1000));
    return c;
  endfunction

  // Picks a command that exercises the table and the duty loop as they stand now.
  function automatic cmd_t shaped_cmd();
    cmd_t   c;
    longint lo, hi, v, lim;
    lo = longint'(speed_lo);
    hi = longint'(speed_hi);
    case ($urandom_range(0, 11)) inside
      0, 1, 2: begin
        c = rand_cmd(KIND_SET);
        if (hi >= lo) begin
          if ($urandom_range(0, 2) == 0 && cal_count > 0)
            c.speed_value = cal_speed[$urandom_range(0, cal_count - 1)];
          else
            c.speed_value = SPEED_W'(lo + longint'($urandom_range(0, hi - lo)));
        end
      end
      3: begin
        c = rand_cmd(KIND_SET);
        if (lo > 0 && $urandom_range(0, 1) == 1)
          c.speed_value = SPEED_W'($urandom_range(0, lo - 1));
        else if (hi < SPEED_TOP)
          c.speed_value = SPEED_W'(hi + 1 + longint'($urandom_range(0, SPEED_TOP - hi - 1)));
      end
      4, 5, 6: begin
        c = rand_cmd(KIND_REGULATE);
        if ($urandom_range(0, 4) != 0) begin
          v = longint'(c.speed_value) + longint'($urandom_range(0, 4096)) - 2048;
          if (v < 0) v = 0;
          if (v > SPEED_TOP) v = SPEED_TOP;
          c.measured_speed = SPEED_W'(v);
        end
      end
      7, 8, 9: begin
        c = rand_cmd(KIND_STEER);
        lim = longint'(c.steer_limit) << SPEED_FRAC_BITS;
        case ($urandom_range(0, 7))
          0: v = lim;
          1: v = -lim;
          2: v = lim + 1;
          3: v = -lim - 1;
          4: v = longint'($signed(c.steer_factor));
          default: v = longint'($urandom_range(0, 2 * lim)) - lim;
        endcase
        c.steer_factor = FACT_W'(v);
      end
      10: c = rand_cmd(KIND_W'($urandom_range(KIND_FORWARD, KIND_STOP)));
      default: c = rand_cmd(KIND_W'($urandom_range(0, 7)));
    endcase
    return c;
  endfunction

  // Start stays high from one beat to the next unless an idle burst is drawn.
  task automatic send_cmd(input cmd_t c);
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      start <= 1'b0;
      cmd <= rand_cmd(KIND_W'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_command(c));
    cmds_sent++;
  endtask

  task automatic issue(input logic [KIND_W-1:0] k, input logic [DUTY_W-1:0] d,
                       input logic [SPEED_W-1:0] s, input logic [SPEED_W-1:0] m,
                       input logic signed [FACT_W-1:0] f, input logic [LIMIT_W-1:0] l);
    cmd_t c;
    c.kind = k;
    c.entry_duty = d;
    c.speed_value = s;
    c.measured_speed = m;
    c.steer_factor = f;
    c.steer_limit = l;
    send_cmd(c);
  endtask

  // Lowers start and waits until every outstanding result is back.
  task automatic quiesce();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DUTY_MAX: duty_max_r = data[DUTY_W-1:0];
      CFG_GAIN:     gain_r = data[GAIN_W-1:0];
      CFG_OFFSET:   offset_r = data[OFFS_W-1:0];
      default: ;
    endcase
    regs_written++;
  endtask

  // Upper data bits beyond each register's width are filled with noise.
  task automatic program_regs(input logic [DUTY_W-1:0] dm, input logic [GAIN_W-1:0] g,
                              input logic [OFFS_W-1:0] off, input bit spare);
    quiesce();
    write_reg(CFG_DUTY_MAX, dm);
    write_reg(CFG_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom), g});
    write_reg(CFG_OFFSET, {(CFG_DATA_W - OFFS_W)'($urandom), off});
    if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // One calibration run: fill the table, pick a direction, then drive the loop.
  task automatic run_session();
    cmd_t   c;
    int     n;
    longint s;
    bit     sorted;
    gap_odds = quiet_tail ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40));
    repeat ($urandom_range(0, 2)) send_cmd(rand_cmd(KIND_W'($urandom_range(0, 7))));
    if ($urandom_range(0, 4) != 0) send_cmd(rand_cmd(KIND_CLEAR));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
    sorted = ($urandom_range(0, 4) != 0);
    s = $urandom_range(0, 4096);
    repeat (n) begin
      c = rand_cmd(KIND_LOAD);
      if (sorted) begin
        s = s + longint'($urandom_range(0, 'h20000));
        if (s > SPEED_TOP) s = SPEED_TOP;
        c.speed_value = SPEED_W'(s);
      end
      send_cmd(c);
    end
    case ($urandom_range(0, 3))
      0: send_cmd(rand_cmd(KIND_FORWARD));
      1: send_cmd(rand_cmd(KIND_BACKWARD));
      2: begin
        send_cmd(rand_cmd(KIND_FORWARD));
        send_cmd(rand_cmd(KIND_BACKWARD));
      end
      default: send_cmd(rand_cmd(KIND_STOP));
    endcase
    repeat ($urandom_range(4, 14)) send_cmd(shaped_cmd());
  endtask

  task automatic test_directed_commands();
    gap_odds = 0;
    // A stopped wheel ignores regulate and steer.
    issue(KIND_REGULATE, 12'd0, 24'hFFFFFF, 24'h000000, 20'sd0, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh7FFFF, 10'd1000);
    issue(KIND_SET, 12'd0, 24'h000100, 24'h0, 20'sd0, 10'd0);
    issue(KIND_LOAD, 12'hFFF, 24'h000000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_LOAD, 12'h000, 24'h001000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_LOAD, 12'd2500, 24'hFFFFFF, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'h000000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'hFFFFFF, 24'h0, 20'sd0, 10'd0);
    issue(KIND_FORWARD, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh7FFFF, 10'd1000);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh80000, 10'd1000);
    issue(KIND_SET, 12'd0, 24'h000800, 24'h0, 20'sd0, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh00100, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, -20'sd1000, 10'd5);
    // Backward with forward still set: the steering sign stays positive.
    issue(KIND_BACKWARD, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh00200, 10'd1);
    issue(KIND_STOP, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
    issue(KIND_BACKWARD, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, -20'sd1000, 10'd10);
    issue(KIND_STEER, 12'd0, 24'h0, 24'h0, 20'sh7FFFF, 10'd0);
    issue(KIND_REGULATE, 12'd0, 24'hFFFFFF, 24'h000000, 20'sd0, 10'd0);
    issue(KIND_REGULATE, 12'd0, 24'h000000, 24'hFFFFFF, 20'sd0, 10'd0);
    issue(KIND_CLEAR, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'h000100, 24'h0, 20'sd0, 10'd0);
    // Unsorted entries leave a gap that no neighboring pair covers.
    issue(KIND_LOAD, 12'd100, 24'h003000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_LOAD, 12'd200, 24'h001000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_LOAD, 12'd300, 24'h002000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'h002800, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'h000800, 24'h0, 20'sd0, 10'd0);
    issue(KIND_SET, 12'd0, 24'h004000, 24'h0, 20'sd0, 10'd0);
    issue(KIND_FORWARD, 12'd0, 24'h0, 24'h0, 20'sd0, 10'd0);
  endtask

  task automatic test_table_full();
    cmd_t   c;
    longint s;
    gap_odds = 25;
    send_cmd(rand_cmd(KIND_CLEAR));
    s = $urandom_range(0, 255);
    repeat (TABLE_DEPTH + 2) begin
      c = rand_cmd(KIND_LOAD);
      s = s + longint'($urandom_range(1, 'h40000));
      if (s > SPEED_TOP) s = SPEED_TOP;
      c.speed_value = SPEED_W'(s);
      send_cmd(c);
    end
    // The top entry makes set speed scan the whole table.
    c = rand_cmd(KIND_SET);
    c.speed_value = speed_hi;
    send_cmd(c);
    c.speed_value = speed_lo;
    send_cmd(c);
    repeat (8) send_cmd(shaped_cmd());
  endtask

  task automatic test_register_sweep();
    int                p;
    logic [DUTY_W-1:0] dm;
    logic [GAIN_W-1:0] g;
    logic [OFFS_W-1:0] off;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin dm = 12'd4095; g = 6'd63; off = 10'd1023; end
        1: begin dm = 12'd1;    g = 6'd0;  off = 10'd0;    end
        2: begin dm = 12'd2048; g = 6'd1;  off = 10'd512;  end
        3: begin dm = 12'd4095; g = 6'd0;  off = 10'd0;    end
        4: begin dm = 12'd1;    g = 6'd63; off = 10'd1023; end
        default: begin
          dm = DUTY_W'($urandom_range(1, 4095));
          g = GAIN_W'($urandom);
          off = OFFS_W'($urandom);
        end
      endcase
      program_regs(dm, g, off, p == 0);
      while (cmds_sent < 100 + (p + 1) * 270) run_session();
    end
  endtask

  task automatic test_quiet_tail();
    quiet_tail = 1'b1;
    gap_odds = 0;
    program_regs(DUTY_MAX_RESET, GAIN_RESET, OFFSET_RESET, 1'b0);
    while (cmds_sent < ITEM_TARGET) run_session();
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with nothing expected, got %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("duty", want.duty, result.duty);
        check_field("drive_forward", want.drive_forward, result.drive_forward);
        check_field("drive_backward", want.drive_backward, result.drive_backward);
        check_field("status", want.status, result.status);
        check_field("lowest_speed", want.lowest_speed, result.lowest_speed);
        check_field("highest_speed", want.highest_speed, result.highest_speed);
        check_field("moving", want.moving, result.moving);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("wheel_speed_controller regression: fail");
      $finish;
    end
  end

  initial begin
    duty_max_r = DUTY_MAX_RESET;
    gain_r = GAIN_RESET;
    offset_r = OFFSET_RESET;
    fwd_now = 1'b0;
    bwd_now = 1'b0;
    duty_now = '0;
    base_now = '0;
    calibrated = 1'b0;
    cal_count = 0;
    speed_lo = '1;
    speed_hi = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_table_full();
    test_register_sweep();
    test_quiet_tail();
    quiesce();
    repeat (40) @(posedge clk);
    $display("Sent %0d commands and checked %0d result beats under %0d register writes.",
             cmds_sent, results_seen, regs_written);
    $display("Set speed found a bracketing pair %0d times; %0d field mismatches.",
             bracket_hits, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("wheel_speed_controller regression: pass");
    end else begin
      $display("wheel_speed_controller regression: fail");
    end
    $finish;
  end

endmodule
